// ----- rtl/core/fqd_pkg.sv -----
// Package with shared types and codes for the FIFO queue with delete-by-value.
package fqd_pkg;

    localparam int unsigned DATA_W = 32;

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_REMOVE  = 2'd1,
        CMD_DUMP    = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_FULL     = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_ENTRY    = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_LOAD   = 3'd1,
        CELL_MATCH  = 3'd2,
        CELL_SHIFT  = 3'd3,
        CELL_ROTATE = 3'd4
    } cell_op_t;

    typedef enum logic [1:0] {
        FSM_IDLE   = 2'd0,
        FSM_REMOVE = 2'd1,
        FSM_DUMP   = 2'd2
    } fsm_state_t;

    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [DATA_W-1:0] entry;
        logic                     last;
    } out_item_t;

    typedef struct packed {
        cell_op_t                 op;
        logic signed [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

// ----- rtl/core/fifo_queue_with_delete_by_value.sv -----
// Enqueue, no-op and empty dump: output register loaded at acceptance, shown next cycle;
// remove latches per-slot compares, then shifts the cell chain and loads the output; dump
// emits the head, then one entry per cycle while results are taken (occupancy results in
// all). One enqueue per cycle if results are taken; remove and dump hold input until done.
// Reset: aresetn (synchronous, active low) empties the queue and the output register;
// slot contents are not cleared and are never read before written.
module fifo_queue_with_delete_by_value #(
    parameter int unsigned DEPTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  fqd_pkg::in_item_t  s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output fqd_pkg::out_item_t m_payload
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned IDX_W = $clog2(DEPTH);

    fqd_pkg::fsm_state_t state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                m_valid_reg, m_valid_next;
    fqd_pkg::out_item_t  m_payload_reg, out_item;
    logic                out_load;
    logic                out_free;
    logic                full;
    logic                dump_last;
    logic                any_match;
    fqd_pkg::cell_ctrl_t cell_ctrl;

    logic signed [fqd_pkg::DATA_W-1:0] cell_data [DEPTH];
    logic [DEPTH:0]                    found_chain;

    assign out_free  = !m_valid_reg || m_ready;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign dump_last = (CNT_W'(idx_reg) == (count_reg - CNT_W'(1)));
    assign any_match = found_chain[DEPTH];
    assign found_chain[0] = 1'b0;

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Chain of slots: slot 0 is the head, each slot reads its neighbor toward the tail.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [fqd_pkg::DATA_W-1:0] next_data;
        if (i == DEPTH - 1) begin : g_end
            assign next_data = cell_data[i];
        end else begin : g_mid
            assign next_data = cell_data[i+1];
        end

        fqd_cell u_cell (
            .aclk      (aclk),
            .ctrl      (cell_ctrl),
            .is_tail   (count_reg == CNT_W'(i)),
            .is_end    (count_reg == CNT_W'(i + 1)),
            .occupied  (CNT_W'(i) < count_reg),
            .next_data (next_data),
            .head_data (cell_data[0]),
            .found_in  (found_chain[i]),
            .found_out (found_chain[i+1]),
            .data_out  (cell_data[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fqd_pkg::FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        out_load        = 1'b0;
        out_item        = '0;
        out_item.status = fqd_pkg::ST_DONE;
        out_item.last   = 1'b1;
        cell_ctrl.op    = fqd_pkg::CELL_HOLD;
        cell_ctrl.value = s_payload.value;
        s_ready         = (state_reg == fqd_pkg::FSM_IDLE) && out_free;

        case (state_reg)
            fqd_pkg::FSM_IDLE: begin
                if (s_valid && s_ready) begin
                    case (fqd_pkg::cmd_t'(s_payload.cmd))
                        fqd_pkg::CMD_ENQUEUE: begin
                            // Drop the value when every slot is taken.
                            out_load = 1'b1;
                            if (full) begin
                                out_item.status = fqd_pkg::ST_FULL;
                            end else begin
                                cell_ctrl.op = fqd_pkg::CELL_LOAD;
                                count_next   = count_reg + CNT_W'(1);
                            end
                        end
                        fqd_pkg::CMD_REMOVE: begin
                            // Latch per-slot compare results, shift next cycle.
                            cell_ctrl.op = fqd_pkg::CELL_MATCH;
                            state_next   = fqd_pkg::FSM_REMOVE;
                        end
                        fqd_pkg::CMD_DUMP: begin
                            if (count_reg == '0) begin
                                out_load        = 1'b1;
                                out_item.status = fqd_pkg::ST_EMPTY;
                            end else begin
                                idx_next   = '0;
                                state_next = fqd_pkg::FSM_DUMP;
                            end
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            fqd_pkg::FSM_REMOVE: begin
                // Output register is free here: nothing was loaded at acceptance.
                out_load   = 1'b1;
                state_next = fqd_pkg::FSM_IDLE;
                if (any_match) begin
                    cell_ctrl.op = fqd_pkg::CELL_SHIFT;
                    count_next   = count_reg - CNT_W'(1);
                end else begin
                    out_item.status = fqd_pkg::ST_NOTFOUND;
                end
            end
            fqd_pkg::FSM_DUMP: begin
                // Emit the head and rotate it to the tail; after occupancy turns
                // the queue is back in its original order.
                if (out_free) begin
                    out_load        = 1'b1;
                    out_item.status = fqd_pkg::ST_ENTRY;
                    out_item.entry  = cell_data[0];
                    out_item.last   = dump_last;
                    cell_ctrl.op    = fqd_pkg::CELL_ROTATE;
                    idx_next        = idx_reg + IDX_W'(1);
                    if (dump_last) begin
                        state_next = fqd_pkg::FSM_IDLE;
                    end
                end
            end
            default: begin
                state_next = fqd_pkg::FSM_IDLE;
            end
        endcase
    end

    // Hold a result until the consumer takes it.
    assign m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (out_load) begin
            m_payload_reg <= out_item;
        end
    end

    a_dump_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fqd_pkg::FSM_DUMP) |-> (count_reg != '0))
        else $error("dump in progress on an empty queue");

    a_remove_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fqd_pkg::FSM_REMOVE) |=> m_valid_reg)
        else $error("remove gave no result");

    a_enqueue_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_payload.cmd == fqd_pkg::CMD_ENQUEUE) && !full)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("enqueue did not advance occupancy");

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == fqd_pkg::FSM_IDLE))
        else $error("input taken while busy");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != fqd_pkg::FSM_IDLE) |=> (count_reg <= CNT_W'(DEPTH)))
        else $error("occupancy beyond depth");

endmodule

// ----- rtl/core/fqd_cell.sv -----
// One queue slot: holds an entry, compares it, and hands data along the chain.
module fqd_cell (
    input  logic                             aclk,
    input  fqd_pkg::cell_ctrl_t              ctrl,
    input  logic                             is_tail,
    input  logic                             is_end,
    input  logic                             occupied,
    input  logic signed [fqd_pkg::DATA_W-1:0] next_data,
    input  logic signed [fqd_pkg::DATA_W-1:0] head_data,
    input  logic                             found_in,
    output logic                             found_out,
    output logic signed [fqd_pkg::DATA_W-1:0] data_out
);

    logic signed [fqd_pkg::DATA_W-1:0] data_reg;
    logic signed [fqd_pkg::DATA_W-1:0] data_next;
    logic                              match_reg;
    logic                              match_next;

    // Any match at or before this slot pulls the entry behind it forward.
    assign found_out = found_in | match_reg;
    assign data_out  = data_reg;

    always_comb begin
        data_next  = data_reg;
        match_next = match_reg;
        case (ctrl.op)
            fqd_pkg::CELL_LOAD: begin
                if (is_tail) begin
                    data_next = ctrl.value;
                end
            end
            fqd_pkg::CELL_MATCH: begin
                match_next = occupied && (data_reg == ctrl.value);
            end
            fqd_pkg::CELL_SHIFT: begin
                if (found_out) begin
                    data_next = next_data;
                end
            end
            fqd_pkg::CELL_ROTATE: begin
                if (is_end) begin
                    data_next = head_data;
                end else if (occupied) begin
                    data_next = next_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg  <= data_next;
        match_reg <= match_next;
    end

endmodule

// ----- tb/fqd_checker.sv -----
// Checker for the FIFO queue with delete-by-value: predicts results and compares them.
module fqd_checker #(
    parameter int unsigned DEPTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  fqd_pkg::in_item_t  s_payload,
    input  logic               m_valid,
    input  logic               m_ready,
    input  fqd_pkg::out_item_t m_payload,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Queue contents, head at index 0, and the results still owed by the block.
    logic signed [fqd_pkg::DATA_W-1:0] held_values [$];
    fqd_pkg::out_item_t                owed_results [$];
    int                                errors = 0;

    assign fail_count = errors;

    task automatic report_error(input string what, input logic [fqd_pkg::DATA_W-1:0] got,
                                input logic [fqd_pkg::DATA_W-1:0] want);
        if (errors < 100) begin
            $display("ERROR at %0t ns: %s got %0h expected %0h", $time, what, got, want);
        end
        errors++;
    endtask

    // Apply one command to the queue copy and append the results it owes.
    task automatic apply_command(input fqd_pkg::in_item_t item);
        fqd_pkg::out_item_t res;
        int                 hit;
        res        = '0;
        res.last   = 1'b1;
        res.status = fqd_pkg::ST_DONE;
        case (fqd_pkg::cmd_t'(item.cmd))
            fqd_pkg::CMD_ENQUEUE: begin
                if (held_values.size() >= DEPTH) begin
                    res.status = fqd_pkg::ST_FULL;
                end else begin
                    held_values.push_back(item.value);
                end
                owed_results.push_back(res);
            end
            fqd_pkg::CMD_REMOVE: begin
                hit = -1;
                foreach (held_values[i]) begin
                    if (hit < 0 && held_values[i] == item.value) begin
                        hit = i;
                    end
                end
                if (hit < 0) begin
                    res.status = fqd_pkg::ST_NOTFOUND;
                end else begin
                    held_values.delete(hit);
                end
                owed_results.push_back(res);
            end
            fqd_pkg::CMD_DUMP: begin
                if (held_values.size() == 0) begin
                    res.status = fqd_pkg::ST_EMPTY;
                    owed_results.push_back(res);
                end else begin
                    foreach (held_values[i]) begin
                        res.status = fqd_pkg::ST_ENTRY;
                        res.entry  = held_values[i];
                        res.last   = (i == held_values.size() - 1);
                        owed_results.push_back(res);
                    end
                end
            end
            default: begin
                owed_results.push_back(res);
            end
        endcase
    endtask

    task automatic check_result(input fqd_pkg::out_item_t got);
        fqd_pkg::out_item_t want;
        if (owed_results.size() == 0) begin
            report_error("unexpected result, status", got.status, '0);
        end else begin
            want = owed_results.pop_front();
            if (got.status !== want.status) begin
                report_error("status", got.status, want.status);
            end
            if (got.entry !== want.entry) begin
                report_error("entry", got.entry, want.entry);
            end
            if (got.last !== want.last) begin
                report_error("last", got.last, want.last);
            end
        end
    endtask

    // Check outgoing results before predicting from this edge's input transaction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            held_values.delete();
            owed_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                check_result(m_payload);
            end
            if (s_valid && s_ready) begin
                apply_command(s_payload);
            end
        end
        pending = owed_results.size();
    end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the FIFO queue with delete-by-value: stimulus, flow control and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH = 16;
    localparam int RANDOM_ITEMS   = 400;
    localparam int HOLDOFF_CYCLES = 80;   // long receiver stall to back up the queue
    localparam int HOLDOFF_AFTER  = 150;  // results taken before the long stall starts
    localparam int DRAIN_CYCLES   = 40;   // settle time after the last owed result

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    fqd_pkg::in_item_t  s_payload = '0;
    logic               m_ready   = 1'b0;
    logic               s_ready;
    logic               m_valid;
    fqd_pkg::out_item_t m_payload;
    int                 fail_count;
    int                 pending_results;

    // Small pool of values so that removes and duplicates hit often.
    logic [fqd_pkg::DATA_W-1:0] value_pool [8];
    int                         send_quiet = 0;   // items left in a no-gap stretch

    // 2 ns clock.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    fifo_queue_with_delete_by_value #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

    fqd_checker #(
        .DEPTH(DEPTH)
    ) checker_inst (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload),
        .fail_count(fail_count),
        .pending  (pending_results)
    );

    // Offer one transaction: idle for a random gap, then hold valid and payload
    // steady until the block accepts. Return right after the accepting edge.
    task automatic send_cmd(input fqd_pkg::cmd_t cmd, input logic [fqd_pkg::DATA_W-1:0] value);
        int gap;
        @(negedge aclk);
        if (send_quiet > 0) begin
            gap = 0;
            send_quiet--;
        end else begin
            gap = $urandom_range(0, 10);
            // Now and then start a burst with no gaps at all.
            if ($urandom_range(0, 19) == 0) begin
                send_quiet = $urandom_range(10, 30);
            end
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_payload.cmd   <= cmd;
        s_payload.value <= value;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // Pick a value: mostly from the pool, sometimes anything in the full range.
    function automatic logic [fqd_pkg::DATA_W-1:0] pick_value();
        if ($urandom_range(0, 4) == 0) begin
            return $urandom;
        end
        return value_pool[$urandom_range(0, 7)];
    endfunction

    // Hard limit on the run.
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Receiver: draw a stall per result, then take it. Once, hold off for a long
    // stretch while the sender keeps offering, so the block backs up and drops ready.
    initial begin
        int stall;
        int recv_quiet;
        int taken;
        bit held_off;
        recv_quiet = 0;
        taken      = 0;
        held_off   = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (!held_off && taken >= HOLDOFF_AFTER) begin
                held_off = 1'b1;
                stall    = HOLDOFF_CYCLES;
            end else if (recv_quiet > 0) begin
                stall = 0;
                recv_quiet--;
            end else begin
                stall = $urandom_range(0, 10);
                if ($urandom_range(0, 19) == 0) begin
                    recv_quiet = $urandom_range(10, 40);
                end
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            taken++;
        end
    end

    // Stimulus and verdict.
    initial begin
        logic [fqd_pkg::DATA_W-1:0] tail_value;
        int                         pick;
        bit                         drain_phase;
        foreach (value_pool[i]) begin
            value_pool[i] = $urandom;
        end

        // Hold reset, then release it on a falling edge.
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty-queue cases and the unused command code.
        send_cmd(fqd_pkg::CMD_DUMP, '0);
        send_cmd(fqd_pkg::CMD_REMOVE, 32'h0000_1234);
        send_cmd(fqd_pkg::CMD_NOP, 32'hFFFF_FFFF);

        // Fill to capacity with extreme values and a duplicate pair.
        send_cmd(fqd_pkg::CMD_ENQUEUE, 32'h8000_0000);
        send_cmd(fqd_pkg::CMD_ENQUEUE, 32'h7FFF_FFFF);
        send_cmd(fqd_pkg::CMD_ENQUEUE, 32'h0000_0000);
        send_cmd(fqd_pkg::CMD_ENQUEUE, 32'hFFFF_FFFF);
        send_cmd(fqd_pkg::CMD_ENQUEUE, 32'h0000_0005);
        send_cmd(fqd_pkg::CMD_ENQUEUE, 32'h0000_0005);
        tail_value = '0;
        for (int k = 6; k < DEPTH; k++) begin
            tail_value = $urandom;
            send_cmd(fqd_pkg::CMD_ENQUEUE, tail_value);
        end

        // Enqueue on a full queue drops the value; dump all sixteen entries.
        send_cmd(fqd_pkg::CMD_ENQUEUE, 32'hDEAD_BEEF);
        send_cmd(fqd_pkg::CMD_DUMP, '0);

        // Remove the first of two duplicates, the head, the tail, then a miss.
        send_cmd(fqd_pkg::CMD_REMOVE, 32'h0000_0005);
        send_cmd(fqd_pkg::CMD_REMOVE, 32'h8000_0000);
        send_cmd(fqd_pkg::CMD_REMOVE, tail_value);
        send_cmd(fqd_pkg::CMD_REMOVE, 32'h1357_9BDF);
        send_cmd(fqd_pkg::CMD_DUMP, '0);

        // Random: pick a fill-heavy or drain-heavy phase every 40 items so the queue swings
        // between full and empty; removes mostly hit values from the pool.
        drain_phase = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                drain_phase = $urandom_range(0, 1);
            end
            pick = $urandom_range(0, 99);
            if (pick < (drain_phase ? 25 : 60)) begin
                send_cmd(fqd_pkg::CMD_ENQUEUE, pick_value());
            end else if (pick < (drain_phase ? 82 : 86)) begin
                send_cmd(fqd_pkg::CMD_REMOVE, pick_value());
            end else if (pick < 97) begin
                send_cmd(fqd_pkg::CMD_DUMP, $urandom);
            end else begin
                send_cmd(fqd_pkg::CMD_NOP, $urandom);
            end
        end

        // Drop valid and wait for the block to deliver everything owed.
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending_results == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/fqd_pkg.sv
rtl/core/fqd_cell.sv
rtl/core/fifo_queue_with_delete_by_value.sv
tb/fqd_checker.sv
tb/tb.sv
